/* hw/rtl/rmsu_pkg.sv */
`timescale 1ns / 1ps

package rmsu_pkg;

   // field widths
   localparam int unsigned WEIGHT_W   = 16;
   localparam int unsigned CACHE_W    = 32;
   localparam int unsigned RATE_W     = 16;
   localparam int unsigned CLIP_W     = 15;
   localparam int unsigned CSR_IDX_W  = 3;

   // datapath widths
   localparam int unsigned X_W        = 50;   // radicand, padded to an even width
   localparam int unsigned ROOT_W     = X_W / 2;
   localparam int unsigned REMS_W     = ROOT_W + 2;
   localparam int unsigned NUM_W      = 35;   // step * |g| * 16
   localparam int unsigned QUO_W      = NUM_W + 1;
   localparam int unsigned REMD_W     = ROOT_W;
   localparam int unsigned REGT_W     = 18;
   localparam int unsigned WN_W       = 43;

   localparam logic [RATE_W:0] ONE_Q16 = 17'h10000;

   // register reset values
   localparam logic [RATE_W-1:0] DECAY_RST = 16'd62259;
   localparam logic [RATE_W-1:0] EPS_RST   = 16'd1;
   localparam logic [CLIP_W-1:0] CLIP_RST  = 15'd20480;
   localparam logic [RATE_W-1:0] STEP_RST  = 16'd66;
   localparam logic [RATE_W-1:0] REG_RST   = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECAY = 3'd0,
      CSR_EPS   = 3'd1,
      CSR_CLIP  = 3'd2,
      CSR_STEP  = 3'd3,
      CSR_REG   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [RATE_W-1:0] cache_decay;
      logic [RATE_W-1:0] smooth_epsilon;
      logic [CLIP_W-1:0] clip_limit;
      logic [RATE_W-1:0] learn_rate;
      logic [RATE_W-1:0] reg_coef;
   } cfg_type;

   // per-item data that rides alongside the root and divide pipes
   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic signed [REGT_W-1:0]   regt;
      logic                       gneg;
      logic [NUM_W-1:0]           num;
      logic [CACHE_W-1:0]         cnew;
      logic                       sat_c;
   } side_type;

endpackage

/* hw/rtl/rmsprop_weight_update.sv */
`timescale 1ns / 1ps

// RMSprop update of one weight element per beat, with gradient clipping and
// weight decay. Pulse req_start with a weight, its gradient and its cache
// entry; exactly one result comes back as a one-cycle pulse on rsp_valid,
// in request order. A new beat may be started every cycle and busy is
// always low, so the block takes one element per clock. The pipeline has
// 4 stages of multiply and cache math, 25 stages of square root (one root
// bit each), 37 stages of divide (a rounding stage plus one quotient bit
// each) and the output register. There is no back pressure: the receiver
// must take every rsp_valid beat when it appears. Registers on the csr port
// must be written only while no beat is in flight; the block does not check.
module rmsprop_weight_update (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_start,
   output logic                                 busy,
   input  logic signed [rmsu_pkg::WEIGHT_W-1:0] req_weight_in,
   input  logic signed [rmsu_pkg::WEIGHT_W-1:0] req_grad_in,
   input  logic [rmsu_pkg::CACHE_W-1:0]         req_cache_in,
   // response
   output logic                                 rsp_valid,
   output logic signed [rmsu_pkg::WEIGHT_W-1:0] rsp_weight_out,
   output logic [rmsu_pkg::CACHE_W-1:0]         rsp_cache_out,
   output logic                                 rsp_saturated,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rmsu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmsu_pkg::RATE_W-1:0]          csr_wdata
);

   // control registers; unknown indexes are dropped
   rmsu_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cache_decay    <= rmsu_pkg::DECAY_RST;
         cfg_ff.smooth_epsilon <= rmsu_pkg::EPS_RST;
         cfg_ff.clip_limit     <= rmsu_pkg::CLIP_RST;
         cfg_ff.learn_rate     <= rmsu_pkg::STEP_RST;
         cfg_ff.reg_coef       <= rmsu_pkg::REG_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmsu_pkg::CSR_DECAY: begin
               cfg_ff.cache_decay <= csr_wdata;
            end
            rmsu_pkg::CSR_EPS: begin
               cfg_ff.smooth_epsilon <= csr_wdata;
            end
            rmsu_pkg::CSR_CLIP: begin
               cfg_ff.clip_limit <= csr_wdata[rmsu_pkg::CLIP_W-1:0];
            end
            rmsu_pkg::CSR_STEP: begin
               cfg_ff.learn_rate <= csr_wdata;
            end
            rmsu_pkg::CSR_REG: begin
               cfg_ff.reg_coef <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // front end: cache update, clip, step numerator, decay term, radicand
   logic                        fr_valid;
   logic [rmsu_pkg::X_W-1:0]    fr_x;
   rmsu_pkg::side_type          fr_side;

   rmsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_start && !busy),
      .weight    (req_weight_in),
      .grad      (req_grad_in),
      .cache     (req_cache_in),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .out_x     (fr_x),
      .out_side  (fr_side)
   );

   // root of (cache + eps) in units of 2^-20
   logic                          sq_valid;
   logic [rmsu_pkg::ROOT_W-1:0]   sq_root;
   rmsu_pkg::side_type            sq_side;

   rmsu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_x      (fr_x),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // step magnitude = round(num / root)
   logic                          dv_valid;
   logic [rmsu_pkg::QUO_W-1:0]    dv_quo;
   logic                          dv_dzero;
   rmsu_pkg::side_type            dv_side;

   rmsu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_dzero (dv_dzero),
      .out_side  (dv_side)
   );

   // final: w - term - regt, clamped to Q3.12
   logic [40:0]                     tmag;
   logic signed [41:0]              term;
   logic signed [rmsu_pkg::WN_W-1:0] wn;
   logic                            w_hi;
   logic                            w_lo;

   always_comb begin
      if (dv_side.num == '0) begin
         tmag = '0;
      end else if (dv_dzero) begin
         // zero root with a live gradient: force saturation
         tmag = 41'h100_0000_0000;
      end else begin
         tmag = 41'(dv_quo);
      end
   end

   assign term = dv_side.gneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
   assign wn   = rmsu_pkg::WN_W'(dv_side.weight) - rmsu_pkg::WN_W'(term)
               - rmsu_pkg::WN_W'(dv_side.regt);
   assign w_hi = (wn > $signed(43'sd32767));
   assign w_lo = (wn < -$signed(43'sd32768));

   logic                                 vld_ff;
   logic signed [rmsu_pkg::WEIGHT_W-1:0] wout_ff;
   logic [rmsu_pkg::CACHE_W-1:0]         cout_ff;
   logic                                 sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (w_hi) begin
         wout_ff <= 16'sh7FFF;
      end else if (w_lo) begin
         wout_ff <= 16'sh8000;
      end else begin
         wout_ff <= wn[rmsu_pkg::WEIGHT_W-1:0];
      end
      cout_ff <= dv_side.cnew;
      sat_ff  <= w_hi || w_lo || dv_side.sat_c;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_weight_out = wout_ff;
   assign rsp_cache_out  = cout_ff;
   assign rsp_saturated  = sat_ff;

endmodule

/* hw/rtl/rmsu_front.sv */
`timescale 1ns / 1ps

module rmsu_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [rmsu_pkg::WEIGHT_W-1:0] weight,
   input  logic signed [rmsu_pkg::WEIGHT_W-1:0] grad,
   input  logic [rmsu_pkg::CACHE_W-1:0]         cache,
   input  rmsu_pkg::cfg_type                    cfg,
   output logic                                 out_valid,
   output logic [rmsu_pkg::X_W-1:0]             out_x,
   output rmsu_pkg::side_type                   out_side
);

   // stage 1: magnitudes, clip, first products
   logic [15:0]        gmag_in;
   logic [14:0]        gcmag_in;
   logic [47:0]        cprod_in;
   logic [30:0]        gsq_in;
   logic signed [32:0] regp_in;

   logic               vld1_ff;
   logic signed [15:0] w1_ff;
   logic               gneg1_ff;
   logic [14:0]        gcmag1_ff;
   logic [47:0]        cprod1_ff;
   logic [30:0]        gsq1_ff;
   logic signed [32:0] regp1_ff;

   assign gmag_in  = grad[15] ? 16'(-grad) : 16'(grad);
   assign gcmag_in = (gmag_in > {1'b0, cfg.clip_limit}) ? cfg.clip_limit : gmag_in[14:0];
   assign cprod_in = cache * cfg.cache_decay;
   assign gsq_in   = gmag_in * gmag_in;
   assign regp_in  = $signed({1'b0, cfg.reg_coef}) * weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      w1_ff     <= weight;
      gneg1_ff  <= grad[15];
      gcmag1_ff <= gcmag_in;
      cprod1_ff <= cprod_in;
      gsq1_ff   <= gsq_in;
      regp1_ff  <= regp_in;
   end

   // stage 2: gradient-square weighting, step numerator, decay rounding
   logic [16:0]        comp_in;
   logic [47:0]        gterm_in;
   logic [30:0]        sprod_in;
   logic [32:0]        regp_mag;
   logic [32:0]        regp_rnd;
   logic [16:0]        regt_mag;
   logic signed [17:0] regt_in;

   logic               vld2_ff;
   logic signed [15:0] w2_ff;
   logic               gneg2_ff;
   logic [34:0]        num2_ff;
   logic signed [17:0] regt2_ff;
   logic [47:0]        cprod2_ff;
   logic [47:0]        gterm2_ff;

   assign comp_in  = rmsu_pkg::ONE_Q16 - {1'b0, cfg.cache_decay};
   assign gterm_in = comp_in * gsq1_ff;
   assign sprod_in = cfg.learn_rate * gcmag1_ff;
   assign regp_mag = regp1_ff[32] ? 33'(-regp1_ff) : 33'(regp1_ff);
   assign regp_rnd = regp_mag + 33'd32768;
   assign regt_mag = regp_rnd[32:16];
   // ties away from zero
   assign regt_in  = regp1_ff[32] ? -$signed({1'b0, regt_mag}) : $signed({1'b0, regt_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      w2_ff     <= w1_ff;
      gneg2_ff  <= gneg1_ff;
      num2_ff   <= {sprod_in, 4'b0000};
      regt2_ff  <= regt_in;
      cprod2_ff <= cprod1_ff;
      gterm2_ff <= gterm_in;
   end

   // stage 3: new cache, rounded half up to Q8.24
   logic [48:0] acc_in;
   logic [48:0] accr_in;
   logic [32:0] cfull_in;

   logic               vld3_ff;
   logic signed [15:0] w3_ff;
   logic               gneg3_ff;
   logic [34:0]        num3_ff;
   logic signed [17:0] regt3_ff;
   logic [31:0]        cnew3_ff;
   logic               satc3_ff;

   assign acc_in   = 49'(cprod2_ff) + 49'(gterm2_ff);
   assign accr_in  = acc_in + 49'd32768;
   assign cfull_in = accr_in[48:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      w3_ff    <= w2_ff;
      gneg3_ff <= gneg2_ff;
      num3_ff  <= num2_ff;
      regt3_ff <= regt2_ff;
      cnew3_ff <= cfull_in[32] ? 32'hFFFF_FFFF : cfull_in[31:0];
      satc3_ff <= cfull_in[32];
   end

   // stage 4: radicand (cache + eps) << 16
   logic [32:0]        v_in;
   logic               vld4_ff;
   logic [rmsu_pkg::X_W-1:0] x4_ff;
   rmsu_pkg::side_type side4_ff;

   assign v_in = 33'(cnew3_ff) + 33'(cfg.smooth_epsilon);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      x4_ff           <= {1'b0, v_in, 16'h0000};
      side4_ff.weight <= w3_ff;
      side4_ff.regt   <= regt3_ff;
      side4_ff.gneg   <= gneg3_ff;
      side4_ff.num    <= num3_ff;
      side4_ff.cnew   <= cnew3_ff;
      side4_ff.sat_c  <= satc3_ff;
   end

   assign out_valid = vld4_ff;
   assign out_x     = x4_ff;
   assign out_side  = side4_ff;

`ifndef SYNTHESIS
   // with legal operand widths the cache never overflows 32 bits
   a_cache_fits: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> !satc3_ff)
      else $error("cache clamp acted");
`endif

endmodule

/* hw/rtl/rmsu_sqrt.sv */
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per stage.
module rmsu_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [rmsu_pkg::X_W-1:0]        in_x,
   input  rmsu_pkg::side_type              in_side,
   output logic                            out_valid,
   output logic [rmsu_pkg::ROOT_W-1:0]     out_root,
   output rmsu_pkg::side_type              out_side
);

   localparam int unsigned STG = rmsu_pkg::ROOT_W;

   logic                          vld_ff  [1:STG];
   logic [rmsu_pkg::ROOT_W-1:0]   root_ff [1:STG];
   logic [rmsu_pkg::REMS_W-1:0]   rem_ff  [1:STG];
   logic [rmsu_pkg::X_W-1:0]      x_ff    [1:STG];
   rmsu_pkg::side_type            side_ff [1:STG];

   genvar k;
   for (k = 0; k < STG; k++) begin : g_stage
      logic                        p_vld;
      logic [rmsu_pkg::ROOT_W-1:0] p_root;
      logic [rmsu_pkg::REMS_W-1:0] p_rem;
      logic [rmsu_pkg::X_W-1:0]    p_x;
      rmsu_pkg::side_type          p_side;
      logic [rmsu_pkg::REMS_W+1:0] work;
      logic [rmsu_pkg::REMS_W+1:0] trial;
      logic                        take;
      logic [rmsu_pkg::REMS_W+1:0] diff;
      logic [rmsu_pkg::ROOT_W-1:0] root_in;
      logic [rmsu_pkg::REMS_W-1:0] rem_in;

      if (k == 0) begin : g_head
         assign p_vld  = in_valid;
         assign p_root = '0;
         assign p_rem  = '0;
         assign p_x    = in_x;
         assign p_side = in_side;
      end else begin : g_body
         assign p_vld  = vld_ff[k];
         assign p_root = root_ff[k];
         assign p_rem  = rem_ff[k];
         assign p_x    = x_ff[k];
         assign p_side = side_ff[k];
      end

      assign work    = {p_rem, p_x[rmsu_pkg::X_W-1 -: 2]};
      assign trial   = {{(rmsu_pkg::REMS_W - rmsu_pkg::ROOT_W){1'b0}}, p_root, 2'b01};
      assign take    = (work >= trial);
      assign diff    = work - trial;
      assign root_in = {p_root[rmsu_pkg::ROOT_W-2:0], take};
      assign rem_in  = take ? diff[rmsu_pkg::REMS_W-1:0] : work[rmsu_pkg::REMS_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[k+1] <= root_in;
         rem_ff[k+1]  <= rem_in;
         x_ff[k+1]    <= {p_x[rmsu_pkg::X_W-3:0], 2'b00};
         side_ff[k+1] <= p_side;
      end
   end

   assign out_valid = vld_ff[STG];
   assign out_root  = root_ff[STG];
   assign out_side  = side_ff[STG];

`ifndef SYNTHESIS
   // floor root: leftover never exceeds twice the root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG] |-> (rem_ff[STG] <= {1'b0, root_ff[STG], 1'b0}))
      else $error("square root remainder out of range");
`endif

endmodule

/* hw/rtl/rmsu_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage; dividend bits shift out of
// the top of nq while quotient bits shift into the bottom.
module rmsu_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [rmsu_pkg::ROOT_W-1:0]     in_root,
   input  rmsu_pkg::side_type              in_side,
   output logic                            out_valid,
   output logic [rmsu_pkg::QUO_W-1:0]      out_quo,
   output logic                            out_dzero,
   output rmsu_pkg::side_type              out_side
);

   localparam int unsigned STG = rmsu_pkg::QUO_W;

   // pre stage: rounded dividend num + root/2
   logic                          vld0_ff;
   logic [rmsu_pkg::QUO_W-1:0]    n0_ff;
   logic [rmsu_pkg::ROOT_W-1:0]   d0_ff;
   rmsu_pkg::side_type            side0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      n0_ff    <= rmsu_pkg::QUO_W'(in_side.num) + rmsu_pkg::QUO_W'(in_root[rmsu_pkg::ROOT_W-1:1]);
      d0_ff    <= in_root;
      side0_ff <= in_side;
   end

   logic                          vld_ff  [1:STG];
   logic [rmsu_pkg::QUO_W-1:0]    nq_ff   [1:STG];
   logic [rmsu_pkg::REMD_W-1:0]   rem_ff  [1:STG];
   logic [rmsu_pkg::ROOT_W-1:0]   d_ff    [1:STG];
   rmsu_pkg::side_type            side_ff [1:STG];

   genvar k;
   for (k = 0; k < STG; k++) begin : g_stage
      logic                        p_vld;
      logic [rmsu_pkg::QUO_W-1:0]  p_nq;
      logic [rmsu_pkg::REMD_W-1:0] p_rem;
      logic [rmsu_pkg::ROOT_W-1:0] p_d;
      rmsu_pkg::side_type          p_side;
      logic [rmsu_pkg::REMD_W:0]   work;
      logic [rmsu_pkg::REMD_W:0]   diff;
      logic                        take;
      logic [rmsu_pkg::REMD_W-1:0] rem_in;

      if (k == 0) begin : g_head
         assign p_vld  = vld0_ff;
         assign p_nq   = n0_ff;
         assign p_rem  = '0;
         assign p_d    = d0_ff;
         assign p_side = side0_ff;
      end else begin : g_body
         assign p_vld  = vld_ff[k];
         assign p_nq   = nq_ff[k];
         assign p_rem  = rem_ff[k];
         assign p_d    = d_ff[k];
         assign p_side = side_ff[k];
      end

      assign work   = {p_rem, p_nq[rmsu_pkg::QUO_W-1]};
      assign take   = (work >= {1'b0, p_d});
      assign diff   = work - {1'b0, p_d};
      assign rem_in = take ? diff[rmsu_pkg::REMD_W-1:0] : work[rmsu_pkg::REMD_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         nq_ff[k+1]   <= {p_nq[rmsu_pkg::QUO_W-2:0], take};
         rem_ff[k+1]  <= rem_in;
         d_ff[k+1]    <= p_d;
         side_ff[k+1] <= p_side;
      end
   end

   assign out_valid = vld_ff[STG];
   assign out_quo   = nq_ff[STG];
   assign out_dzero = (d_ff[STG] == '0);
   assign out_side  = side_ff[STG];

`ifndef SYNTHESIS
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STG] && (d_ff[STG] != '0)) |-> (rem_ff[STG] < d_ff[STG]))
      else $error("divider remainder not below divisor");
`endif

endmodule

/* sim/rmsprop_weight_update_tb.sv */
`timescale 1ns / 1ps

// Checks the RMSprop element update: every request beat is run through a
// local predictor and the expected weight, cache and flag are queued; each
// rsp_valid beat is compared against the oldest entry.
module rmsprop_weight_update_tb;

   localparam int LATENCY = 67;

   typedef struct {
      logic signed [rmsu_pkg::WEIGHT_W-1:0] weight;
      logic [rmsu_pkg::CACHE_W-1:0]         cache;
      logic                                 sat;
   } update_type;

   typedef struct {
      logic signed [rmsu_pkg::WEIGHT_W-1:0] weight;
      logic signed [rmsu_pkg::WEIGHT_W-1:0] grad;
      logic [rmsu_pkg::CACHE_W-1:0]         cache;
      bit                                   known;   // expected result typed in below
      update_type                           want;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic busy;
   logic signed [rmsu_pkg::WEIGHT_W-1:0] req_weight_in = '0;
   logic signed [rmsu_pkg::WEIGHT_W-1:0] req_grad_in = '0;
   logic [rmsu_pkg::CACHE_W-1:0] req_cache_in = '0;
   logic rsp_valid;
   logic signed [rmsu_pkg::WEIGHT_W-1:0] rsp_weight_out;
   logic [rmsu_pkg::CACHE_W-1:0] rsp_cache_out;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rmsu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rmsu_pkg::RATE_W-1:0] csr_wdata = '0;

   rmsu_pkg::cfg_type cfg;
   update_type        pending_updates[$];
   int                mismatches = 0;
   stim_type          directed[$];

   always #6 clock = ~clock;

   rmsprop_weight_update dut (.*);

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Fixed-point RMSprop step for one element under the current settings.
   function automatic update_type rmsprop_step(logic signed [rmsu_pkg::WEIGHT_W-1:0] w_in,
                                               logic signed [rmsu_pkg::WEIGHT_W-1:0] g_in,
                                               logic [rmsu_pkg::CACHE_W-1:0] c_in);
      update_type res;
      longint w, g, gclip, lim, term, regt, wn, prod;
      longint unsigned gmag, acc, cnew, v, r, num, tmag;
      w = longint'(w_in);
      g = longint'(g_in);
      res.sat = 1'b0;
      // cache takes the gradient before clipping
      gmag = g < 0 ? -g : g;
      acc = longint'(c_in) * cfg.cache_decay
            + (65536 - longint'(cfg.cache_decay)) * (gmag * gmag);
      cnew = (acc + 32768) >> 16;
      if (cnew > 64'hFFFF_FFFF) begin
         cnew = 64'hFFFF_FFFF;
         res.sat = 1'b1;
      end
      lim = longint'(cfg.clip_limit);
      gclip = g;
      if (gclip > lim) gclip = lim;
      if (gclip < -lim) gclip = -lim;
      v = cnew + cfg.smooth_epsilon;
      r = int_sqrt(v << 16);
      num = longint'(cfg.learn_rate) * (gclip < 0 ? -gclip : gclip) * 16;
      if (num == 0) tmag = 0;
      else if (r == 0) tmag = 64'd1 << 40;   // divide by zero root: force saturation
      else tmag = (num + (r >> 1)) / r;
      term = gclip < 0 ? -longint'(tmag) : longint'(tmag);
      // weight decay, rounded half away from zero
      prod = longint'(cfg.reg_coef) * w;
      regt = prod >= 0 ? (prod + 32768) >>> 16 : -((-prod + 32768) >>> 16);
      wn = w - term - regt;
      if (wn > 32767) begin
         wn = 32767;
         res.sat = 1'b1;
      end else if (wn < -32768) begin
         wn = -32768;
         res.sat = 1'b1;
      end
      res.weight = wn[rmsu_pkg::WEIGHT_W-1:0];
      res.cache = cnew[rmsu_pkg::CACHE_W-1:0];
      return res;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic drop_start();
      req_start <= 1'b0;
   endtask

   // Random gap, mostly zero or short, occasionally long.
   task automatic sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return;
      drop_start();
      if (pick < 93) idle_cycles($urandom_range(1, 3));
      else idle_cycles($urandom_range(10, 90));
   endtask

   task automatic write_csr(rmsu_pkg::csr_index_type idx,
                            logic [rmsu_pkg::RATE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         rmsu_pkg::CSR_DECAY: cfg.cache_decay = value;
         rmsu_pkg::CSR_EPS:   cfg.smooth_epsilon = value;
         rmsu_pkg::CSR_CLIP:  cfg.clip_limit = value[rmsu_pkg::CLIP_W-1:0];
         rmsu_pkg::CSR_STEP:  cfg.learn_rate = value;
         rmsu_pkg::CSR_REG:   cfg.reg_coef = value;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [rmsu_pkg::RATE_W-1:0] decay,
                            logic [rmsu_pkg::RATE_W-1:0] eps,
                            logic [rmsu_pkg::RATE_W-1:0] clip,
                            logic [rmsu_pkg::RATE_W-1:0] step,
                            logic [rmsu_pkg::RATE_W-1:0] regc);
      write_csr(rmsu_pkg::CSR_DECAY, decay);
      write_csr(rmsu_pkg::CSR_EPS, eps);
      write_csr(rmsu_pkg::CSR_CLIP, clip);
      write_csr(rmsu_pkg::CSR_STEP, step);
      write_csr(rmsu_pkg::CSR_REG, regc);
   endtask

   // One request beat; start is left high when beats run back to back.
   task automatic send_element(logic signed [rmsu_pkg::WEIGHT_W-1:0] w,
                               logic signed [rmsu_pkg::WEIGHT_W-1:0] g,
                               logic [rmsu_pkg::CACHE_W-1:0] c);
      req_start <= 1'b1;
      req_weight_in <= w;
      req_grad_in <= g;
      req_cache_in <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_updates.push_back(rmsprop_step(w, g, c));
   endtask

   // Idle point for register writes: all results home, pipe drained.
   task automatic drain();
      drop_start();
      while (pending_updates.size() != 0) @(posedge clock);
      idle_cycles(LATENCY + 4);
   endtask

   task automatic report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
   endtask

   // Response checker: sampled on the edge that ends the strobe cycle.
   always @(posedge clock) begin
      update_type exp_u;
      if (!reset && rsp_valid) begin
         if (pending_updates.size() == 0) begin
            report("unexpected beat weight", 0, rsp_weight_out);
         end else begin
            exp_u = pending_updates.pop_front();
            if (rsp_weight_out !== exp_u.weight) report("weight", exp_u.weight, rsp_weight_out);
            if (rsp_cache_out !== exp_u.cache) report("cache", exp_u.cache, rsp_cache_out);
            if (rsp_saturated !== exp_u.sat) report("saturated", exp_u.sat, rsp_saturated);
         end
      end
   end

   function automatic stim_type row(int w, int g, longint unsigned c, bit known = 0,
                                    int ew = 0, longint unsigned ec = 0, bit es = 0);
      stim_type s;
      s.weight = rmsu_pkg::WEIGHT_W'(w);
      s.grad = rmsu_pkg::WEIGHT_W'(g);
      s.cache = rmsu_pkg::CACHE_W'(c);
      s.known = known;
      s.want.weight = rmsu_pkg::WEIGHT_W'(ew);
      s.want.cache = rmsu_pkg::CACHE_W'(ec);
      s.want.sat = es;
      return s;
   endfunction

   // Random element: mostly realistic magnitudes, some full range.
   task automatic random_element();
      logic signed [rmsu_pkg::WEIGHT_W-1:0] w, g;
      logic [rmsu_pkg::CACHE_W-1:0] c;
      w = rmsu_pkg::WEIGHT_W'($urandom);
      g = rmsu_pkg::WEIGHT_W'($urandom);
      c = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         g = $signed(g) >>> $urandom_range(0, 10);
         c = c >> $urandom_range(0, 31);
      end
      send_element(w, g, c);
   endtask

   initial begin : main
      int n;
      update_type got;
      cfg = '{cache_decay: rmsu_pkg::DECAY_RST, smooth_epsilon: rmsu_pkg::EPS_RST,
              clip_limit: rmsu_pkg::CLIP_RST, learn_rate: rmsu_pkg::STEP_RST,
              reg_coef: rmsu_pkg::REG_RST};
      idle_cycles(4);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under reset settings. Zero gradient and zero cache with
      // zero decay coefficient leaves weight alone; cache stays zero.
      directed.push_back(row(0, 0, 0, 1, 0, 0, 0));
      directed.push_back(row(32767, 0, 0, 1, 32767, 0, 0));
      directed.push_back(row(-32768, 0, 0, 1, -32768, 0, 0));
      directed.push_back(row(0, 32767, 0));
      directed.push_back(row(0, -32768, 0));
      directed.push_back(row(32767, 32767, 32'hFFFF_FFFF));
      directed.push_back(row(-32768, -32768, 32'hFFFF_FFFF));
      directed.push_back(row(100, 1, 0));
      directed.push_back(row(-100, -1, 1));
      directed.push_back(row(-32768, 4096, 32'h0100_0000));
      foreach (directed[i]) begin
         send_element(directed[i].weight, directed[i].grad, directed[i].cache);
         if (directed[i].known) begin
            got = pending_updates[$];
            if (got.weight !== directed[i].want.weight || got.cache !== directed[i].want.cache
                || got.sat !== directed[i].want.sat)
               report("table row", i, got.weight);
         end
      end
      drain();

      // Zero decay and eps: zero gradients give a zero root, nonzero ones do not.
      write_all(16'd0, 16'd0, 16'd32767, 16'd65535, 16'd65535);
      send_element(16'sd0, 16'sd0, 32'd0);
      send_element(16'sd1000, 16'sd0, 32'd0);
      send_element(16'sd0, 16'sd5, 32'd0);
      send_element(16'sd0, -16'sd5, 32'd0);
      send_element(16'sh8000, 16'sh8000, 32'd0);
      send_element(16'sd32767, 16'sd32767, 32'hFFFF_FFFF);
      drain();

      // Zero clip limit: weight only decays.
      write_all(16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd32768);
      send_element(16'sd32767, 16'sd32767, 32'hFFFF_FFFF);
      send_element(16'sh8000, 16'sh8000, 32'd0);
      send_element(16'sd3, 16'sd1, 32'd7);
      send_element(-16'sd3, -16'sd1, 32'd7);
      drain();

      // Random phases over a spread of settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all(rmsu_pkg::DECAY_RST, rmsu_pkg::EPS_RST, {1'b0, rmsu_pkg::CLIP_RST},
                         rmsu_pkg::STEP_RST, rmsu_pkg::REG_RST);
            1: write_all(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
            2: write_all(16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
            default: write_all(rmsu_pkg::RATE_W'($urandom), rmsu_pkg::RATE_W'($urandom),
                               rmsu_pkg::RATE_W'($urandom), rmsu_pkg::RATE_W'($urandom),
                               $urandom_range(0, 3) == 0 ? rmsu_pkg::RATE_W'($urandom)
                                  : rmsu_pkg::RATE_W'($urandom_range(0, 600)));
         endcase
         n = 90;
         for (int k = 0; k < n; k++) begin
            if (phase == 3 && k == 45) begin
               // hold off until every expected beat is back
               drop_start();
               while (pending_updates.size() != 0) @(posedge clock);
            end
            random_element();
            if (phase != 1) begin
               if ($urandom_range(0, 1) == 0) sender_gap();
            end
         end
         drain();
      end

      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule

/* filelist.f */
hw/rtl/rmsu_pkg.sv
hw/rtl/rmsu_front.sv
hw/rtl/rmsu_sqrt.sv
hw/rtl/rmsu_div.sv
hw/rtl/rmsprop_weight_update.sv
sim/rmsprop_weight_update_tb.sv
